/* hdl/lbp_pkg.sv */
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the line terminated byte packetizer.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int PACKET_BYTES_DEFAULT = 16;

   localparam logic [7:0] BYTE_CR = 8'd13;
   localparam logic [7:0] BYTE_LF = 8'd10;

   typedef enum logic [0:0] {
      ST_COLLECT = 1'b0,
      ST_DRAIN   = 1'b1
   } state_type;

   // chain control broadcast to every cell
   typedef struct packed {
      logic shift;
      logic load_en;
   } cell_ctrl_type;

endpackage

/* hdl/line_terminated_byte_packetizer.sv */
// ----------------------------------------------------------------------------
// line_terminated_byte_packetizer
// Collects bytes into a row of cells; CR or LF, or a byte arriving at a full
// buffer, drains the row one byte per transfer through an output register.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_ready  data_byte
//  rsp_      out        rsp_valid/rsp_ready  payload_byte, packet_length,
//                                            continued, last_of_packet
//
//  A byte that only appends is accepted and written straight into the next cell.
//  A flush is accepted and then drains one packet byte per output transfer, the cells
//  shifting toward cell 0 one position per output transfer.
//  req_ready is low while the buffer drains; rsp_ready low stalls the shift.
//  Reset empties the buffer; cell contents are not cleared.
// ----------------------------------------------------------------------------
module line_terminated_byte_packetizer #(
   parameter int PACKET_BYTES = lbp_pkg::PACKET_BYTES_DEFAULT,
   localparam int CNT_W = $clog2(PACKET_BYTES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_payload_byte,
   output logic [CNT_W-1:0] rsp_packet_length,
   output logic             rsp_continued,
   output logic             rsp_last_of_packet
);

   lbp_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       len_ff, len_in;
   logic                   more_ff, more_in;
   logic [7:0]             hold_ff, hold_in;
   logic                   hold_v_ff, hold_v_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic [CNT_W-1:0]       out_len_ff, out_len_in;
   logic                   out_more_ff, out_more_in;
   logic                   out_last_ff, out_last_in;

   lbp_pkg::cell_ctrl_type ctrl;
   logic [CNT_W-1:0]       wr_index;
   logic [7:0]             wr_data;
   logic [7:0]             cell_data [PACKET_BYTES];
   logic                   is_term;

   assign is_term = (req_data_byte == lbp_pkg::BYTE_CR) ||
                    (req_data_byte == lbp_pkg::BYTE_LF);
   assign wr_data = (state_ff == lbp_pkg::ST_DRAIN) ? hold_ff : req_data_byte;

   genvar gi;
   generate
      for (gi = 0; gi < PACKET_BYTES; gi++) begin : g_cell
         logic [7:0] next_byte;
         if (gi + 1 < PACKET_BYTES) begin : g_mid
            assign next_byte = cell_data[gi + 1];
         end else begin : g_end
            assign next_byte = 8'd0;
         end
         lbp_cell #(
            .CNT_W (CNT_W),
            .INDEX (gi)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .wr_index  (wr_index),
            .wr_data   (wr_data),
            .next_data (next_byte),
            .data      (cell_data[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      more_in      = more_ff;
      hold_in      = hold_ff;
      hold_v_in    = hold_v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_len_in   = out_len_ff;
      out_more_in  = out_more_ff;
      out_last_in  = out_last_ff;
      ctrl.shift   = 1'b0;
      ctrl.load_en = 1'b0;
      wr_index     = count_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         lbp_pkg::ST_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               priority if (is_term) begin
                  if (count_ff != '0) begin
                     len_in    = count_ff;
                     more_in   = 1'b0;
                     hold_v_in = 1'b0;
                     state_in  = lbp_pkg::ST_DRAIN;
                  end
               end else if (count_ff == CNT_W'(PACKET_BYTES)) begin
                  len_in    = count_ff;
                  more_in   = 1'b1;
                  hold_in   = req_data_byte;
                  hold_v_in = 1'b1;
                  state_in  = lbp_pkg::ST_DRAIN;
               end else begin
                  ctrl.load_en = 1'b1;
                  count_in     = count_ff + CNT_W'(1);
               end
            end
         end
         lbp_pkg::ST_DRAIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = cell_data[0];
               out_len_in   = len_ff;
               out_more_in  = more_ff;
               out_last_in  = (count_ff == CNT_W'(1));
               ctrl.shift   = 1'b1;
               if (count_ff == CNT_W'(1)) begin
                  // last byte: on a split packet the byte that caused it starts the next one
                  wr_index     = '0;
                  ctrl.load_en = hold_v_ff;
                  count_in     = hold_v_ff ? CNT_W'(1) : '0;
                  state_in     = lbp_pkg::ST_COLLECT;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = lbp_pkg::ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbp_pkg::ST_COLLECT;
         count_ff     <= '0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      more_ff     <= more_in;
      hold_ff     <= hold_in;
      out_byte_ff <= out_byte_in;
      out_len_ff  <= out_len_in;
      out_more_ff <= out_more_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_packet_length  = out_len_ff;
   assign rsp_continued      = out_more_ff;
   assign rsp_last_of_packet = out_last_ff;

endmodule

/* hdl/lbp_cell.sv */
// ----------------------------------------------------------------------------
// lbp_cell
// One byte slot of the packet buffer. Loads on load_en when the write index
// matches its own position, otherwise takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module lbp_cell #(
   parameter int CNT_W = 5,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  lbp_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]      wr_index,
   input  logic [7:0]            wr_data,
   input  logic [7:0]            next_data,
   output logic [7:0]            data
);

   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic       hit;

   assign hit  = ctrl.load_en && (wr_index == CNT_W'(INDEX));
   assign data = data_ff;

   always_comb begin
      priority if (hit) begin
         data_in = wr_data;
      end else if (ctrl.shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* hdl/lbp_checker.sv */
// ----------------------------------------------------------------------------
// lbp_sva
// Port-level checks for the line terminated byte packetizer, bound to the top.
// ----------------------------------------------------------------------------
module lbp_sva #(
   parameter int PACKET_BYTES = lbp_pkg::PACKET_BYTES_DEFAULT,
   localparam int CNT_W = $clog2(PACKET_BYTES + 1)
) (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [7:0]       rsp_payload_byte,
   input logic [CNT_W-1:0] rsp_packet_length,
   input logic             rsp_continued,
   input logic             rsp_last_of_packet
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte) &&
         $stable(rsp_packet_length) && $stable(rsp_last_of_packet))
      else $error("rsp transfer changed while stalled");

   a_split_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_continued |-> rsp_packet_length == CNT_W'(PACKET_BYTES))
      else $error("split packet is not full length");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_packet_length != '0 &&
         rsp_packet_length <= CNT_W'(PACKET_BYTES))
      else $error("packet length out of range");

   a_busy_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_packet |-> !req_ready)
      else $error("input taken in the middle of a packet");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind line_terminated_byte_packetizer lbp_sva #(
   .PACKET_BYTES (PACKET_BYTES)
) u_lbp_sva (.*);

/* dv/lbp_checker.sv */
// ----------------------------------------------------------------------------
// lbp_checker
// Watches both channels of the packetizer. Every accepted input byte is run
// through a line-buffer predictor, and the bytes that should come out are
// queued. Each output transfer is compared field by field with the oldest
// queued byte.
// ----------------------------------------------------------------------------
module lbp_checker #(
   parameter int PACKET_BYTES = lbp_pkg::PACKET_BYTES_DEFAULT,
   localparam int CNT_W = $clog2(PACKET_BYTES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [7:0]       rsp_payload_byte,
   input  logic [CNT_W-1:0] rsp_packet_length,
   input  logic             rsp_continued,
   input  logic             rsp_last_of_packet,
   output int               fail_count,
   output int               beats_owed,
   output int               beats_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]       payload;
      logic [CNT_W-1:0] length;
      logic             more;
      logic             last;
   } beat_type;

   logic [7:0]  line_buf [PACKET_BYTES];
   int unsigned line_fill;
   beat_type    owed_beats [$];
   int          mismatches;
   int          checked;

   initial begin
      mismatches    = 0;
      checked       = 0;
      line_fill     = 0;
   end

   function automatic void flush_line(input logic more);
      beat_type b;
      for (int k = 0; k < int'(line_fill); k++) begin
         b.payload = line_buf[k];
         b.length  = CNT_W'(line_fill);
         b.more    = more;
         b.last    = (k + 1 == int'(line_fill));
         owed_beats.push_back(b);
      end
   endfunction

   function automatic void take_char(input logic [7:0] c);
      if (c == lbp_pkg::BYTE_CR || c == lbp_pkg::BYTE_LF) begin
         if (line_fill > 0) begin
            flush_line(1'b0);
            line_fill = 0;
         end
      end else if (line_fill >= PACKET_BYTES) begin
         // full buffer goes out as a split packet, new byte starts the next
         flush_line(1'b1);
         line_buf[0] = c;
         line_fill   = 1;
      end else begin
         line_buf[line_fill] = c;
         line_fill++;
      end
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      beat_type want;
      if (reset) begin
         line_fill = 0;
         owed_beats.delete();
      end else begin
         if (req_valid && req_ready)
            take_char(req_data_byte);
         if (rsp_valid && rsp_ready) begin
            if (owed_beats.size() == 0) begin
               $error("unexpected transfer: payload_byte 0x%0h with nothing owed",
                      rsp_payload_byte);
               mismatches++;
            end else begin
               want = owed_beats.pop_front();
               check_field("payload_byte", want.payload, rsp_payload_byte);
               check_field("packet_length", want.length, rsp_packet_length);
               check_field("continued", want.more, rsp_continued);
               check_field("last_of_packet", want.last, rsp_last_of_packet);
               checked++;
            end
         end
      end
      fail_count    <= mismatches;
      beats_owed    <= owed_beats.size();
      beats_checked <= checked;
   end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the line terminated byte packetizer. A directed
// opening covers empty terminators, extreme byte values, a full packet and a
// split; random lines of varied length follow, with bursts of idling on
// both channels except near the end. Checking lives in lbp_checker.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PACKET_BYTES = lbp_pkg::PACKET_BYTES_DEFAULT;
   localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
   localparam int RANDOM_CHARS = 95;
   localparam int CALM_AFTER   = 70;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_data_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_payload_byte;
   logic [CNT_W-1:0] rsp_packet_length;
   logic             rsp_continued;
   logic             rsp_last_of_packet;

   int fail_count;
   int beats_owed;
   int beats_checked;
   int chars_sent = 0;
   bit calm = 1'b0;
   bit gappy = 1'b0;

   line_terminated_byte_packetizer #(.PACKET_BYTES(PACKET_BYTES)) dut (.*);

   lbp_checker #(.PACKET_BYTES(PACKET_BYTES)) checker_i (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results still owed", beats_owed);
      $display("Simulation FAILED");
      $finish;
   end

   // output side back-pressure
   initial begin
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!calm && $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   task automatic send_char(input logic [7:0] c);
      if (!calm && gappy && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   function automatic logic [7:0] pick_text_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == lbp_pkg::BYTE_CR || c == lbp_pkg::BYTE_LF);
      return c;
   endfunction

   initial begin
      int roll;
      int len;
      int directed;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // terminators with nothing pending, extreme bytes, full then split
      gappy = 1'b1;
      send_char(lbp_pkg::BYTE_CR);
      send_char(lbp_pkg::BYTE_LF);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(lbp_pkg::BYTE_CR);
      send_char(lbp_pkg::BYTE_LF);
      for (int k = 0; k < PACKET_BYTES; k++)
         send_char(8'(k * 17 + 1) == lbp_pkg::BYTE_LF ? 8'h5A : 8'(k * 17 + 1));
      send_char(8'h41);
      send_char(lbp_pkg::BYTE_CR);
      directed = chars_sent;

      while (chars_sent < directed + RANDOM_CHARS) begin
         if (chars_sent >= directed + CALM_AFTER)
            calm = 1'b1;
         gappy = 1'($urandom_range(0, 1));
         roll  = $urandom_range(0, 99);
         if (roll < 10) begin
            // raw noise, terminators included
            repeat ($urandom_range(1, 5)) send_char(8'($urandom_range(0, 255)));
         end else begin
            if (roll < 18)
               len = PACKET_BYTES;
            else if (roll < 32)
               len = $urandom_range(PACKET_BYTES - 2, 2 * PACKET_BYTES + 8);
            else
               len = $urandom_range(1, PACKET_BYTES - 2);
            repeat (len) send_char(pick_text_char());
            case ($urandom_range(0, 2))
               0: send_char(lbp_pkg::BYTE_CR);
               1: send_char(lbp_pkg::BYTE_LF);
               default: begin
                  send_char(lbp_pkg::BYTE_CR);
                  send_char(lbp_pkg::BYTE_LF);
               end
            endcase
         end
      end
      send_char(lbp_pkg::BYTE_LF);
      req_valid <= 1'b0;

      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d characters (%0d directed), checked %0d output bytes",
               chars_sent, directed, beats_checked);
      if (fail_count == 0 && beats_owed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count, beats_owed);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/lbp_pkg.sv
hdl/lbp_cell.sv
hdl/line_terminated_byte_packetizer.sv
hdl/lbp_checker.sv
dv/lbp_checker.sv
dv/tb_top.sv
